// ===== rtl/mts_pkg.sv =====
// shared types, constants and melody tables for the melody tone sequencer
// no dependencies; imported by every module under rtl
`default_nettype none

package mts_pkg;

   // request and result payloads
   typedef struct packed {
      logic [3:0] game_state;
      logic [1:0] difficulty;
      logic       music_on;
      logic       error_beep;
   } req_type;

   typedef struct packed {
      logic [10:0] tone_hz;
      logic [2:0]  song_id;
      logic [4:0]  note_index;
   } rsp_type;

   // configuration registers
   typedef struct packed {
      logic [11:0] whole_note_ms;
      logic [9:0]  tempo_step_ms;
      logic [15:0] end_hold_ms;
      logic [11:0] beep_hz;
      logic [11:0] beep_ms;
   } cfg_type;

   localparam logic [2:0] CSR_WHOLE_NOTE = 3'd0;
   localparam logic [2:0] CSR_TEMPO_STEP = 3'd1;
   localparam logic [2:0] CSR_END_HOLD   = 3'd2;
   localparam logic [2:0] CSR_BEEP_HZ    = 3'd3;
   localparam logic [2:0] CSR_BEEP_MS    = 3'd4;

   localparam logic [11:0] RST_WHOLE_NOTE = 12'd1000;
   localparam logic [9:0]  RST_TEMPO_STEP = 10'd250;
   localparam logic [15:0] RST_END_HOLD   = 16'd2000;
   localparam logic [11:0] RST_BEEP_HZ    = 12'd150;
   localparam logic [11:0] RST_BEEP_MS    = 12'd150;

   // game states
   localparam logic [3:0] GS_COUNTDOWN = 4'd3;
   localparam logic [3:0] GS_PLAYING   = 4'd4;
   localparam logic [3:0] GS_LOSS      = 4'd5;
   localparam logic [3:0] GS_WIN       = 4'd6;
   localparam logic [3:0] GS_END       = 4'd7;
   localparam logic [3:0] GS_READJUST  = 4'd8;

   // melody ids
   localparam logic [2:0] SONG_NONE  = 3'd0;
   localparam logic [2:0] SONG_BG    = 3'd1;
   localparam logic [2:0] SONG_COUNT = 3'd2;
   localparam logic [2:0] SONG_GAME  = 3'd3;
   localparam logic [2:0] SONG_WIN   = 3'd4;
   localparam logic [2:0] SONG_LOSS  = 3'd5;

   localparam logic [4:0] LEN_BG    = 5'd16;
   localparam logic [4:0] LEN_COUNT = 5'd7;
   localparam logic [4:0] LEN_GAME  = 5'd20;
   localparam logic [4:0] LEN_WIN   = 5'd16;
   localparam logic [4:0] LEN_LOSS  = 5'd8;

   localparam logic [10:0] TONE_SILENT = 11'd0;
   localparam logic [10:0] TONE_MAX    = 11'd2047;

   // x / 10 == (x * 0xCCCD) >> 19, exact for x below 2**18
   localparam logic [15:0] RECIP_TEN   = 16'hCCCD;
   localparam int unsigned RECIP_SHIFT = 19;

   // play phase, one-hot
   typedef enum logic [3:0] {
      PH_BOUNDARY = 4'b0001,
      PH_NOTE     = 4'b0010,
      PH_BEEP     = 4'b0100,
      PH_HOLD     = 4'b1000
   } phase_type;

   typedef struct packed {
      phase_type  phase;
      logic       beep_pending;
      logic [4:0] note_pos;
   } status_type;

   // one note: pitch and log2 of the note divisor
   typedef struct packed {
      logic [10:0] hz;
      logic [1:0]  div_shift;
   } note_type;

   localparam note_type BG_ROM [16] = '{
      '{11'd330, 2'd2}, '{11'd415, 2'd3}, '{11'd330, 2'd2}, '{11'd494, 2'd2},
      '{11'd440, 2'd3}, '{11'd415, 2'd3}, '{11'd440, 2'd1}, '{11'd330, 2'd2},
      '{11'd330, 2'd2}, '{11'd415, 2'd3}, '{11'd330, 2'd2}, '{11'd494, 2'd2},
      '{11'd523, 2'd3}, '{11'd494, 2'd3}, '{11'd440, 2'd1}, '{TONE_SILENT, 2'd2}};

   localparam note_type COUNT_ROM [7] = '{
      '{11'd330, 2'd2}, '{TONE_SILENT, 2'd2}, '{11'd330, 2'd2}, '{TONE_SILENT, 2'd2},
      '{11'd330, 2'd2}, '{TONE_SILENT, 2'd2}, '{11'd880, 2'd1}};

   localparam note_type GAME_ROM [20] = '{
      '{11'd659, 2'd2}, '{11'd494, 2'd3}, '{11'd523, 2'd3}, '{11'd587, 2'd2},
      '{11'd523, 2'd3}, '{11'd494, 2'd3}, '{11'd440, 2'd2}, '{11'd440, 2'd3},
      '{11'd523, 2'd3}, '{11'd659, 2'd2}, '{11'd587, 2'd3}, '{11'd523, 2'd3},
      '{11'd494, 2'd2}, '{11'd523, 2'd3}, '{11'd587, 2'd2}, '{11'd659, 2'd2},
      '{11'd523, 2'd2}, '{11'd440, 2'd2}, '{11'd440, 2'd2}, '{TONE_SILENT, 2'd2}};

   localparam note_type WIN_ROM [16] = '{
      '{11'd659, 2'd3}, '{11'd784, 2'd3}, '{11'd1047, 2'd3}, '{11'd784, 2'd3},
      '{11'd659, 2'd3}, '{11'd784, 2'd3}, '{11'd1047, 2'd3}, '{11'd784, 2'd3},
      '{11'd698, 2'd3}, '{11'd880, 2'd3}, '{11'd1175, 2'd3}, '{11'd880, 2'd3},
      '{11'd698, 2'd3}, '{11'd880, 2'd3}, '{11'd1175, 2'd3}, '{11'd880, 2'd3}};

   localparam note_type LOSS_ROM [8] = '{
      '{11'd440, 2'd1}, '{11'd349, 2'd1}, '{11'd330, 2'd1}, '{11'd294, 2'd2},
      '{11'd330, 2'd2}, '{11'd349, 2'd2}, '{11'd330, 2'd0}, '{TONE_SILENT, 2'd1}};

   function automatic logic [4:0] song_len(input logic [2:0] song);
      logic [4:0] len;
      case (song)
         SONG_COUNT: len = LEN_COUNT;
         SONG_GAME:  len = LEN_GAME;
         SONG_WIN:   len = LEN_WIN;
         SONG_LOSS:  len = LEN_LOSS;
         default:    len = LEN_BG;
      endcase
      return len;
   endfunction

   // position is always below the melody length here
   function automatic note_type note_lookup(input logic [2:0] song, input logic [4:0] pos);
      note_type n;
      case (song)
         SONG_COUNT: n = COUNT_ROM[pos[2:0]];
         SONG_GAME:  n = GAME_ROM[pos];
         SONG_WIN:   n = WIN_ROM[pos[3:0]];
         SONG_LOSS:  n = LOSS_ROM[pos[2:0]];
         default:    n = BG_ROM[pos[3:0]];
      endcase
      return n;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/mts_dur.sv =====
// note timing: tempo, sounding length and total slot length of one note
// depends on mts_pkg
`default_nettype none

module mts_dur (
   input  logic [11:0] whole_note_ms,
   input  logic [9:0]  tempo_step_ms,
   input  logic [1:0]  difficulty,
   input  logic        game_tune,
   input  logic [1:0]  div_shift,
   output logic [11:0] sound_ms,
   output logic [12:0] gap_ms
);
   import mts_pkg::*;

   logic [11:0] step_total;
   logic [11:0] tempo;
   logic [11:0] dur;
   logic [13:0] triple;
   logic [29:0] prod;
   logic [10:0] tenth;

   // at most 3 * 1023, fits in 12 bits
   assign step_total = {2'b00, tempo_step_ms} * {10'd0, difficulty};

   always_comb begin
      tempo = whole_note_ms;
      if (game_tune) begin
         tempo = (whole_note_ms > step_total) ? (whole_note_ms - step_total) : 12'd1;
      end
   end

   assign dur = tempo >> div_shift;

   // dur * 13 / 10 == dur + (3 * dur) / 10
   assign triple = {2'b00, dur} + {1'b0, dur, 1'b0};
   assign prod   = 30'(triple) * 30'(RECIP_TEN);
   assign tenth  = 11'(prod >> RECIP_SHIFT);

   assign sound_ms = dur;
   assign gap_ms   = {1'b0, dur} + {2'b00, tenth};

endmodule

`default_nettype wire

// ===== rtl/mts_core.sv =====
// sequencer state and per-tick update: song selection, note, beep and hold
// depends on mts_pkg and mts_dur
`default_nettype none

module mts_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  mts_pkg::req_type   item,
   input  mts_pkg::cfg_type   cfg,
   output mts_pkg::rsp_type   rsp,
   output mts_pkg::status_type status
);
   import mts_pkg::*;

   typedef struct packed {
      logic [2:0]  cur_song;
      logic [2:0]  last_song;
      logic [4:0]  note_pos;
      phase_type   phase;
      logic [15:0] ms_cnt;
      logic [11:0] sound_ms;
      logic [12:0] gap_ms;
      logic        beep_pending;
   } seq_state_type;

   seq_state_type state_ff;
   seq_state_type state_in;

   logic        boundary;
   logic [2:0]  sel_song;
   logic [2:0]  sel_last;
   logic [4:0]  sel_pos;
   logic [2:0]  want;
   note_type    note;
   logic [11:0] dur_sound;
   logic [12:0] dur_gap;
   logic        mismatch;
   logic [11:0] beep_len;
   logic [10:0] beep_tone;
   logic        hold_off;
   logic [10:0] tone;
   logic [2:0]  out_song;
   logic [4:0]  out_note;

   function automatic seq_state_type advance_note(input seq_state_type s, input logic no_hold);
      seq_state_type r;
      logic [4:0]    nxt;
      r        = s;
      nxt      = s.note_pos + 5'd1;
      r.ms_cnt = '0;
      r.phase  = PH_BOUNDARY;
      if (nxt >= song_len(s.cur_song)) begin
         r.note_pos = '0;
         if ((s.cur_song == SONG_WIN || s.cur_song == SONG_LOSS) && !no_hold) begin
            r.phase = PH_HOLD;
         end
      end else begin
         r.note_pos = nxt;
      end
      return r;
   endfunction

   assign boundary = item.music_on && (state_ff.phase == PH_BOUNDARY);

   // melody selection at a note boundary, otherwise the stored song
   always_comb begin
      sel_last = state_ff.last_song;
      case (item.game_state)
         GS_COUNTDOWN: want = SONG_COUNT;
         GS_PLAYING:   want = SONG_GAME;
         GS_LOSS: begin
            want     = SONG_LOSS;
            sel_last = SONG_LOSS;
         end
         GS_WIN: begin
            want     = SONG_WIN;
            sel_last = SONG_WIN;
         end
         GS_END, GS_READJUST: want = state_ff.last_song;
         default: want = SONG_BG;
      endcase
      sel_song = state_ff.cur_song;
      sel_pos  = state_ff.note_pos;
      if (boundary) begin
         if (want != state_ff.cur_song) begin
            sel_song = want;
            sel_pos  = '0;
         end
         if (sel_pos >= song_len(sel_song)) begin
            sel_pos = '0;
         end
      end else begin
         sel_last = state_ff.last_song;
      end
   end

   assign note = note_lookup(sel_song, sel_pos);

   mts_dur u_dur (
      .whole_note_ms (cfg.whole_note_ms),
      .tempo_step_ms (cfg.tempo_step_ms),
      .difficulty    (item.difficulty),
      .game_tune     (sel_song == SONG_GAME),
      .div_shift     (note.div_shift),
      .sound_ms      (dur_sound),
      .gap_ms        (dur_gap)
   );

   assign mismatch  = (item.game_state == GS_PLAYING && sel_song != SONG_GAME) ||
                      (item.game_state == GS_WIN     && sel_song != SONG_WIN)  ||
                      (item.game_state == GS_LOSS    && sel_song != SONG_LOSS);
   assign beep_len  = (cfg.beep_ms == '0) ? 12'd1 : cfg.beep_ms;
   assign beep_tone = cfg.beep_hz[11] ? TONE_MAX : cfg.beep_hz[10:0];
   assign hold_off  = (cfg.end_hold_ms == '0);

   always_comb begin
      state_in              = state_ff;
      state_in.beep_pending = state_ff.beep_pending | item.error_beep;
      tone                  = TONE_SILENT;
      out_song              = state_ff.cur_song;
      out_note              = state_ff.note_pos;
      if (item.music_on) begin
         if (boundary) begin
            state_in.cur_song  = sel_song;
            state_in.last_song = sel_last;
            state_in.note_pos  = sel_pos;
            state_in.sound_ms  = dur_sound;
            state_in.gap_ms    = dur_gap;
            state_in.ms_cnt    = '0;
            state_in.phase     = PH_NOTE;
         end
         out_song = state_in.cur_song;
         out_note = state_in.note_pos;

         if (state_in.phase == PH_NOTE) begin
            if (state_in.beep_pending) begin
               state_in.phase  = PH_BEEP;
               state_in.ms_cnt = '0;
            end else if (mismatch) begin
               state_in = advance_note(state_in, hold_off);
            end else begin
               if (state_in.ms_cnt < {4'd0, state_in.sound_ms}) begin
                  tone = note.hz;
               end
               state_in.ms_cnt = state_in.ms_cnt + 16'd1;
               if (state_in.ms_cnt >= {3'd0, state_in.gap_ms}) begin
                  state_in = advance_note(state_in, hold_off);
               end
            end
         end

         if (state_in.phase == PH_BEEP) begin
            tone            = beep_tone;
            state_in.ms_cnt = state_in.ms_cnt + 16'd1;
            if (state_in.ms_cnt >= {4'd0, beep_len}) begin
               state_in.beep_pending = 1'b0;
               state_in = advance_note(state_in, hold_off);
            end
         end else if (state_in.phase == PH_HOLD && out_note == state_in.note_pos &&
                      state_in.ms_cnt < cfg.end_hold_ms) begin
            // hold does not count on the tick that entered it
            state_in.ms_cnt = state_in.ms_cnt + 16'd1;
            if (state_in.ms_cnt >= cfg.end_hold_ms) begin
               state_in.ms_cnt = '0;
               state_in.phase  = PH_BOUNDARY;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.cur_song     <= SONG_NONE;
         state_ff.last_song    <= SONG_WIN;
         state_ff.note_pos     <= '0;
         state_ff.phase        <= PH_BOUNDARY;
         state_ff.ms_cnt       <= '0;
         state_ff.sound_ms     <= '0;
         state_ff.gap_ms       <= '0;
         state_ff.beep_pending <= 1'b0;
      end else if (step) begin
         state_ff <= state_in;
      end
   end

   assign rsp.tone_hz    = tone;
   assign rsp.song_id    = out_song;
   assign rsp.note_index = out_note;

   assign status.phase        = state_ff.phase;
   assign status.beep_pending = state_ff.beep_pending;
   assign status.note_pos     = state_ff.note_pos;

endmodule

`default_nettype wire

// ===== rtl/melody_tone_sequencer.sv =====
// top level of the buzzer melody tone sequencer: handshakes, csr bank, registers
// depends on mts_pkg and mts_core
`default_nettype none

// Buzzer melody sequencer advanced by one request per 1 ms tick. Each request
// carries the game state, difficulty, music enable and an error-beep request;
// each one yields exactly one response with the tone to drive for that
// millisecond (0 is silent), the current melody id and the note position.
// The melody is picked from the game state among five built-in tunes; each
// note sounds for whole_note_ms / divisor ms (the game tune speeds up by
// tempo_step_ms per difficulty level, never below 1 ms) and its slot lasts
// 13/10 of that. An error beep is latched until the next note tick and then
// replaces the rest of that note. Win and loss tunes are followed by
// end_hold_ms of silence. With music off the output is silent and the
// sequence holds in place.
// Throughput is one request per clock while rsp_stall does not back up the
// registers: the request register feeds a single pass of update logic whose
// longest path is the tempo subtract, the divide-by-ten constant multiply and
// the slot-length compare, and the response register takes the result. A
// request sits first in the request register, then in the response register;
// a stalled response can keep it in the request register. The response
// register parts the two sides: while a response waits on rsp_stall, one
// more request is still taken, and req_stall rises only when both are full.
// Csr writes (csr_index 0..4 in register order) are always ready and must
// only be issued while no request is in flight; other indexes are ignored.

module melody_tone_sequencer (
   input  logic             clock,
   input  logic             reset,
   // request channel
   input  logic             req_valid,
   output logic             req_stall,
   input  mts_pkg::req_type req_data,
   // response channel
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output mts_pkg::rsp_type rsp_data,
   // csr write channel
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [15:0]      csr_data
);
   import mts_pkg::*;

   // request register
   logic       in_valid_ff;
   logic       in_valid_in;
   req_type    in_data_ff;

   // response register
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   rsp_type    rsp_data_ff;

   // csr bank
   cfg_type    cfg_ff;
   cfg_type    cfg_in;

   logic       req_accept;
   logic       step_en;
   rsp_type    core_rsp;
   status_type core_status;

   // the held request moves on whenever the response slot is free or drains
   assign step_en    = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = in_valid_ff && !step_en;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (step_en) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step_en) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_data_ff <= req_data;
      end
      if (step_en) begin
         rsp_data_ff <= core_rsp;
      end
   end

   // csr writes, one register per index
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_WHOLE_NOTE: cfg_in.whole_note_ms = csr_data[11:0];
            CSR_TEMPO_STEP: cfg_in.tempo_step_ms = csr_data[9:0];
            CSR_END_HOLD:   cfg_in.end_hold_ms   = csr_data;
            CSR_BEEP_HZ:    cfg_in.beep_hz       = csr_data[11:0];
            CSR_BEEP_MS:    cfg_in.beep_ms       = csr_data[11:0];
            default:        cfg_in               = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.whole_note_ms <= RST_WHOLE_NOTE;
         cfg_ff.tempo_step_ms <= RST_TEMPO_STEP;
         cfg_ff.end_hold_ms   <= RST_END_HOLD;
         cfg_ff.beep_hz       <= RST_BEEP_HZ;
         cfg_ff.beep_ms       <= RST_BEEP_MS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // per-tick sequencer update
   mts_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step_en),
      .item   (in_data_ff),
      .cfg    (cfg_ff),
      .rsp    (core_rsp),
      .status (core_status)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a processed request always lands in the response register
   a_step_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      step_en |=> rsp_valid_ff)
      else $error("processed request did not produce a response");

   // a held request that cannot move stays put
   a_held_req_stays: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !step_en) |=> (in_valid_ff && $stable(in_data_ff)))
      else $error("held request lost or changed");

   // the beep phase only runs with a latched beep
   a_beep_latched: assert property (@(posedge clock) disable iff (reset)
      (core_status.phase == PH_BEEP) |-> core_status.beep_pending)
      else $error("beep phase without pending beep");

   // the end hold always sits at the start of the melody
   a_hold_at_start: assert property (@(posedge clock) disable iff (reset)
      (core_status.phase == PH_HOLD) |-> (core_status.note_pos == '0))
      else $error("end hold with nonzero note position");

endmodule

`default_nettype wire
